@@ src/wcd_pkg.sv @@
// ----------------------------------------------------------------------------
// wcd_pkg
// Shared types and constants for the windowed convergence detector.
// ----------------------------------------------------------------------------
package wcd_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int COST_BITS  = 32;
    localparam int RING_DEPTH = 2 * MAX_WINDOW;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int SUM_W      = COST_BITS + $clog2(MAX_WINDOW);
    localparam int WIN_W      = 6;
    localparam int FRAC_W     = 16;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_IMPR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ITER = 3'd4;

    typedef logic [COST_BITS-1:0] cost_t;
    typedef logic [PTR_W-1:0]     ptr_t;

    typedef struct packed {
        logic  restart;
        cost_t upper_cost;
        cost_t lower_cost;
        logic  upper_usable;
    } in_t;

    typedef struct packed {
        logic             converged;
        logic [CNT_W-1:0] iterations_seen;
    } out_t;

    typedef struct packed {
        logic  en;
        ptr_t  addr;
        cost_t data;
    } ring_wr_t;

    typedef struct packed {
        logic en;
        ptr_t addr_a;
        ptr_t addr_b;
    } ring_rd_t;

endpackage

@@ src/windowed_convergence_detector.sv @@
// ----------------------------------------------------------------------------
// windowed_convergence_detector
// Moving-window mean stall test and upper/lower gap test on a stream of
// per-iteration costs; one verdict and sample count per input beat.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+---------------------
//  input   | s_valid s_ready s_data         | in        | in_t
//  result  | m_valid m_ready m_data         | out       | out_t
//  config  | cfg_valid cfg_ready cfg_index  | in        | cfg_data (16 bits)
//
//  One beat per cycle sustained unless the result channel stalls; each beat
//  passes the input register (with history read), then the result register.
//  The running sums close a loop through one add stage; the multiply only
//  feeds the verdict.
//  Synchronous active-low reset; the history ring is not cleared.
//  A stalled result holds the input stage; s_ready drops only then.
// ----------------------------------------------------------------------------
module windowed_convergence_detector
    import wcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int                PROD_W = SUM_W + FRAC_W + 1;
    localparam int                GAP_W  = COST_BITS + FRAC_W;
    localparam logic [FRAC_W:0]   Q_ONE  = {1'b1, {FRAC_W{1'b0}}};

    function automatic ptr_t ring_back(input ptr_t p, input logic [PTR_W:0] d);
        logic [PTR_W+1:0] diff;
        begin
            diff = {2'b00, p} - {1'b0, d};
            if (diff[PTR_W+1]) begin
                diff = diff + (PTR_W+2)'(RING_DEPTH);
            end
            ring_back = diff[PTR_W-1:0];
        end
    endfunction

    // configuration
    logic              mode_reg;
    logic [WIN_W-1:0]  window_reg;
    logic [FRAC_W-1:0] min_impr_reg;
    logic [FRAC_W-1:0] gap_lim_reg;
    logic [CNT_W-1:0]  min_iter_reg;
    logic              cfg_fire;
    logic              win_write;

    // pipeline and run state
    logic              in_valid_reg, in_valid_next;
    in_t               in_data_reg;
    ptr_t              in_ptr_reg;
    logic              fwd_a_reg, fwd_b_reg;
    cost_t             fwd_data_reg;
    ptr_t              acc_ptr_reg, acc_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  recent_reg, recent_next;
    logic [SUM_W-1:0]  prev_reg, prev_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg;

    logic              accept, fire;
    logic [WIN_W-1:0]  win;
    logic [WIN_W:0]    win2;
    ptr_t              acc_p;
    ring_wr_t          ring_wr;
    ring_rd_t          ring_rd;
    cost_t             rd_a, rd_b;

    logic [CNT_W-1:0]  c_old, c_new;
    logic [SUM_W-1:0]  rs_old, ps_old;
    cost_t             leave_r, leave_p;
    logic [PROD_W-1:0] stall_lhs, stall_rhs;
    logic [GAP_W-1:0]  gap_lhs, gap_rhs;
    cost_t             upper, lower;
    logic              conv;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign win_write = cfg_fire && (cfg_index == REG_WINDOW);

    always_comb begin
        if (window_reg == '0) begin
            win = WIN_W'(1);
        end else if (32'(window_reg) > MAX_WINDOW) begin
            win = WIN_W'(MAX_WINDOW);
        end else begin
            win = window_reg;
        end
    end
    assign win2 = {win, 1'b0};

    assign fire    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign accept  = s_valid && s_ready;

    // history read issued with the beat, for the slot it will occupy
    assign acc_p          = s_data.restart ? '0 : acc_ptr_reg;
    assign ring_rd.en     = accept;
    assign ring_rd.addr_a = ring_back(acc_p, (PTR_W+1)'(win));
    assign ring_rd.addr_b = ring_back(acc_p, (PTR_W+1)'(win2));

    assign ring_wr.en   = fire;
    assign ring_wr.addr = in_ptr_reg;
    assign ring_wr.data = in_data_reg.upper_cost;

    wcd_ring u_ring (
        .aclk      (aclk),
        .wr        (ring_wr),
        .rd        (ring_rd),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    always_comb begin
        acc_ptr_next = acc_ptr_reg;
        if (win_write) begin
            acc_ptr_next = '0;
        end else if (accept) begin
            acc_ptr_next = (acc_p == ptr_t'(RING_DEPTH - 1)) ? '0 : acc_p + 1'b1;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    // sum update and decision
    always_comb begin
        upper  = in_data_reg.upper_cost;
        lower  = in_data_reg.lower_cost;
        c_old  = in_data_reg.restart ? '0 : cnt_reg;
        rs_old = in_data_reg.restart ? '0 : recent_reg;
        ps_old = in_data_reg.restart ? '0 : prev_reg;

        leave_r = '0;
        if (c_old >= CNT_W'(win)) begin
            leave_r = fwd_a_reg ? fwd_data_reg : rd_a;
        end
        leave_p = '0;
        if (c_old >= CNT_W'(win2)) begin
            leave_p = fwd_b_reg ? fwd_data_reg : rd_b;
        end

        recent_next = rs_old + SUM_W'(upper) - SUM_W'(leave_r);
        prev_next   = ps_old + SUM_W'(leave_r) - SUM_W'(leave_p);
        c_new       = (c_old == '1) ? c_old : c_old + 1'b1;

        stall_lhs = PROD_W'(prev_next) * PROD_W'(Q_ONE - {1'b0, min_impr_reg});
        stall_rhs = PROD_W'({recent_next, {FRAC_W{1'b0}}});
        gap_lhs   = {upper - lower, {FRAC_W{1'b0}}};
        gap_rhs   = GAP_W'(lower) * GAP_W'(gap_lim_reg);

        conv = 1'b0;
        if ((c_new >= min_iter_reg) && in_data_reg.upper_usable) begin
            if (!mode_reg) begin
                if (c_new >= CNT_W'(win2)) begin
                    if (prev_next == '0) begin
                        conv = (min_impr_reg != '0);
                    end else begin
                        conv = (stall_lhs < stall_rhs);
                    end
                end
            end else begin
                conv = (lower != '0) && (lower < upper) && (gap_lhs < gap_rhs);
            end
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (win_write) begin
            cnt_next = '0;
        end else if (fire) begin
            cnt_next = c_new;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= 1'b0;
            window_reg   <= WIN_W'(5);
            min_impr_reg <= FRAC_W'(655);
            gap_lim_reg  <= FRAC_W'(5243);
            min_iter_reg <= '0;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_MODE:     mode_reg     <= cfg_data[0];
                REG_WINDOW:   window_reg   <= cfg_data[WIN_W-1:0];
                REG_MIN_IMPR: min_impr_reg <= cfg_data[FRAC_W-1:0];
                REG_GAP_LIM:  gap_lim_reg  <= cfg_data[FRAC_W-1:0];
                REG_MIN_ITER: min_iter_reg <= cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            acc_ptr_reg  <= '0;
            cnt_reg      <= '0;
            recent_reg   <= '0;
            prev_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            acc_ptr_reg  <= acc_ptr_next;
            cnt_reg      <= cnt_next;
            if (win_write) begin
                recent_reg <= '0;
                prev_reg   <= '0;
            end else if (fire) begin
                recent_reg <= recent_next;
                prev_reg   <= prev_next;
            end
        end
    end

    // slot written on the same edge as the read is forwarded
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_data_reg  <= s_data;
            in_ptr_reg   <= acc_p;
            fwd_a_reg    <= fire && (in_ptr_reg == ring_rd.addr_a);
            fwd_b_reg    <= fire && (in_ptr_reg == ring_rd.addr_b);
            fwd_data_reg <= in_data_reg.upper_cost;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg.converged       <= conv;
            m_data_reg.iterations_seen <= c_new;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ src/wcd_ring.sv @@
// ----------------------------------------------------------------------------
// wcd_ring
// Sample history: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module wcd_ring
    import wcd_pkg::*;
(
    input  logic     aclk,
    input  ring_wr_t wr,
    input  ring_rd_t rd,
    output cost_t    rd_data_a,
    output cost_t    rd_data_b
);

    cost_t mem [RING_DEPTH];
    cost_t rd_data_a_reg;
    cost_t rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_a_reg <= mem[rd.addr_a];
            rd_data_b_reg <= mem[rd.addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

@@ src/wcd_checker.sv @@
// ----------------------------------------------------------------------------
// wcd_checker
// Port-level checks for the windowed convergence detector.
// ----------------------------------------------------------------------------
module wcd_checker
    import wcd_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.iterations_seen != '0)
        else $error("result beat with zero sample count");

    a_backpressure_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a stalled result");

endmodule

bind windowed_convergence_detector wcd_checker u_wcd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for windowed_convergence_detector. A driver feeds cost
// samples from a queue while a monitor predicts the verdict and sample count
// of every accepted beat and compares it with the result channel. Directed
// corner cases come first, then randomly configured runs of decaying cost
// trajectories mixed with noise, then one run at the widest window with no
// idling.
// ----------------------------------------------------------------------------
module testbench;
    import wcd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic MODE_STALL = 1'b0;
    localparam logic MODE_GAP   = 1'b1;
    localparam int   Q_ONE       = 65536;
    localparam int   HOLD_CYCLES = 200;
    localparam int   RANDOM_ITEMS = 1600;
    localparam int   WIDE_ITEMS   = 200;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    windowed_convergence_detector u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // predictor state
    logic             cfg_mode;
    logic [WIN_W-1:0] cfg_window;
    logic [FRAC_W-1:0] cfg_min_impr;
    logic [FRAC_W-1:0] cfg_gap_lim;
    logic [CNT_W-1:0] cfg_min_iter;
    cost_t            hist [RING_DEPTH];
    logic [SUM_W-1:0] recent_sum;
    logic [SUM_W-1:0] prev_sum;
    logic [CNT_W-1:0] count;
    ptr_t             wptr;

    in_t  sample_q [$];
    out_t verdict_q [$];
    int   errors = 0;
    int   out_beats = 0;
    int   random_items = 0;
    logic s_fire = 1'b0;
    logic quiet = 1'b0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    // trajectory generator state
    logic [63:0] traj_level = 64'd1000;
    logic [63:0] traj_decay = 64'd0;
    int          seq_left = 0;

    function automatic void queue_sample(in_t b);
        sample_q.insert(sample_q.size(), b);
    endfunction

    function automatic void queue_verdict(out_t r);
        verdict_q.insert(verdict_q.size(), r);
    endfunction

    function automatic void clear_run();
        recent_sum = '0;
        prev_sum   = '0;
        count      = '0;
        wptr       = '0;
    endfunction

    function automatic int window_in_use();
        if (cfg_window == 0)
            return 1;
        if (cfg_window > MAX_WINDOW)
            return MAX_WINDOW;
        return int'(cfg_window);
    endfunction

    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_MODE: begin
                cfg_mode = val[0];
            end
            REG_WINDOW: begin
                cfg_window = val[WIN_W-1:0];
                clear_run();
            end
            REG_MIN_IMPR: begin
                cfg_min_impr = val[FRAC_W-1:0];
            end
            REG_GAP_LIM: begin
                cfg_gap_lim = val[FRAC_W-1:0];
            end
            REG_MIN_ITER: begin
                cfg_min_iter = val[CNT_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic out_t convergence_step(in_t b);
        int          w;
        int          p;
        cost_t       leave_recent;
        cost_t       leave_prev;
        logic [63:0] lhs;
        logic [63:0] rhs;
        out_t        r;
        w = window_in_use();
        leave_recent = '0;
        leave_prev = '0;
        if (b.restart)
            clear_run();
        p = int'(wptr);
        if (count >= w)
            leave_recent = hist[(p + RING_DEPTH - w) % RING_DEPTH];
        if (count >= 2 * w)
            leave_prev = hist[(p + RING_DEPTH - 2 * w) % RING_DEPTH];
        recent_sum = recent_sum + b.upper_cost - leave_recent;
        prev_sum = prev_sum + leave_recent - leave_prev;
        hist[p] = b.upper_cost;
        wptr = ptr_t'((p + 1) % RING_DEPTH);
        if (count != '1)
            count = count + 1'b1;
        r.converged = 1'b0;
        r.iterations_seen = count;
        if (count >= cfg_min_iter && b.upper_usable) begin
            if (cfg_mode == MODE_STALL) begin
                if (count >= 2 * w) begin
                    if (prev_sum == 0) begin
                        r.converged = (cfg_min_impr != 0);
                    end else begin
                        lhs = 64'(prev_sum) * (64'(Q_ONE) - 64'(cfg_min_impr));
                        rhs = 64'(recent_sum) << FRAC_W;
                        r.converged = (lhs < rhs);
                    end
                end
            end else begin
                if (b.lower_cost != 0 && b.lower_cost < b.upper_cost) begin
                    lhs = 64'(b.upper_cost - b.lower_cost) << FRAC_W;
                    rhs = 64'(b.lower_cost) * 64'(cfg_gap_lim);
                    r.converged = (lhs < rhs);
                end
            end
        end
        return r;
    endfunction

    function automatic in_t beat_of(logic rst, cost_t up, cost_t lo, logic usable);
        in_t b;
        b.restart = rst;
        b.upper_cost = up;
        b.lower_cost = lo;
        b.upper_usable = usable;
        return b;
    endfunction

    // decaying cost trajectories with restarts, plus some raw noise
    function automatic in_t next_sample();
        in_t         b;
        logic [63:0] up;
        logic [63:0] lo;
        logic [63:0] noise;
        logic [63:0] g;
        int          pick;
        if ($urandom_range(99) < 6) begin
            b.restart = ($urandom_range(9) == 0);
            b.upper_cost = $urandom;
            b.lower_cost = $urandom;
            b.upper_usable = $urandom_range(1);
            return b;
        end
        b.restart = 1'b0;
        if (seq_left == 0) begin
            b.restart = ($urandom_range(3) != 0);
            seq_left = $urandom_range(160, 20);
            case ($urandom_range(3))
                0: traj_level = 64'($urandom_range(64, 0));
                1: traj_level = 64'($urandom_range(1000000, 1000));
                2: traj_level = 64'($urandom);
                default: traj_level = 64'hFFFF_FFFF - 64'($urandom_range(1000, 0));
            endcase
            traj_decay = $urandom_range(1) ? 64'($urandom_range(3000, 0))
                                           : 64'($urandom_range(300, 0));
        end
        seq_left--;
        if ($urandom_range(49) == 0)
            traj_decay = 64'd0;
        noise = traj_level >> $urandom_range(20, 6);
        up = $urandom_range(1) ? traj_level + noise : traj_level - noise;
        if (up > 64'hFFFF_FFFF)
            up = 64'hFFFF_FFFF;
        traj_level = traj_level - ((traj_level * traj_decay) >> FRAC_W);
        pick = $urandom_range(99);
        if (pick < 5) begin
            lo = up + 64'($urandom_range(1000, 1));
            if (lo > 64'hFFFF_FFFF)
                lo = 64'($urandom);
        end else if (pick < 8) begin
            lo = 64'd0;
        end else if (pick < 11) begin
            lo = up;
        end else begin
            g = 64'($urandom_range(2 * int'(cfg_gap_lim) + 64, 0));
            if (g > 64'(Q_ONE))
                g = 64'(Q_ONE);
            lo = up - ((up * g) >> FRAC_W);
        end
        b.upper_cost = up[31:0];
        b.lower_cost = lo[31:0];
        b.upper_usable = ($urandom_range(99) < 90);
        return b;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endtask

    // monitor: predicts on input beats, checks result beats
    always @(posedge aclk) begin : monitor
        out_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                queue_verdict(convergence_step(s_data));
            s_fire <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                out_beats <= out_beats + 1;
                if (verdict_q.size() == 0) begin
                    flag_mismatch("unexpected result beat", 64'd0, 64'(m_data));
                end else begin
                    want = verdict_q.pop_front();
                    if (m_data.converged !== want.converged)
                        flag_mismatch("converged", 64'(want.converged),
                                      64'(m_data.converged));
                    if (m_data.iterations_seen !== want.iterations_seen)
                        flag_mismatch("iterations_seen", 64'(want.iterations_seen),
                                      64'(m_data.iterations_seen));
                end
            end
        end
    end

    // driver
    always @(negedge aclk) begin
        if (!s_valid || s_fire) begin
            if (sample_q.size() != 0 && (quiet || $urandom_range(99) >= 8)) begin
                s_data <= sample_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off while the sender is still busy
    always @(negedge aclk) begin
        if (!hold_done && out_beats >= 300 && sample_q.size() > 40) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= 8);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        apply_config(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || s_valid || verdict_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_phase();
        int                    n;
        int                    r;
        logic [WIN_W-1:0]      win;
        logic [CFG_DATA_W-1:0] frac;
        write_reg(REG_MODE, (CFG_DATA_W'($urandom) & ~16'h0001)
                            | CFG_DATA_W'($urandom_range(1)));
        r = $urandom_range(99);
        if (r < 5)
            win = '0;
        else if (r < 10)
            win = WIN_W'($urandom_range(63, 33));
        else if (r < 15)
            win = WIN_W'(MAX_WINDOW);
        else
            win = WIN_W'($urandom_range(12, 1));
        write_reg(REG_WINDOW, (CFG_DATA_W'($urandom) & 16'hFFC0) | CFG_DATA_W'(win));
        r = $urandom_range(99);
        frac = (r < 10) ? '0 : (r < 20) ? '1 : (r < 70) ? CFG_DATA_W'($urandom_range(8000, 1))
                                                         : CFG_DATA_W'($urandom);
        write_reg(REG_MIN_IMPR, frac);
        r = $urandom_range(99);
        frac = (r < 10) ? '0 : (r < 20) ? '1 : (r < 70) ? CFG_DATA_W'($urandom_range(8000, 1))
                                                         : CFG_DATA_W'($urandom);
        write_reg(REG_GAP_LIM, frac);
        r = $urandom_range(99);
        frac = (r < 60) ? CFG_DATA_W'($urandom_range(10, 0))
             : (r < 85) ? CFG_DATA_W'($urandom_range(150, 10))
             : (r < 92) ? '1 : CFG_DATA_W'($urandom);
        write_reg(REG_MIN_ITER, frac);
        seq_left = 0;
        n = $urandom_range(220, 60);
        repeat (n)
            queue_sample(next_sample());
        random_items += n;
        drain();
    endtask

    initial begin
        cfg_mode     = MODE_STALL;
        cfg_window   = 6'd5;
        cfg_min_impr = 16'd655;
        cfg_gap_lim  = 16'd5243;
        cfg_min_iter = 16'd0;
        foreach (hist[i])
            hist[i] = '0;
        clear_run();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: stall test on full-scale costs, then unusable upper
        queue_sample(beat_of(1'b1, 32'hFFFF_FFFF, 32'd0, 1'b1));
        repeat (8)
            queue_sample(beat_of(1'b0, 32'hFFFF_FFFF, 32'd0, 1'b1));
        queue_sample(beat_of(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        queue_sample(beat_of(1'b0, 32'hFFFF_FFFF, 32'd0, 1'b0));
        drain();

        // gap test at widest limit; zero window acts as one
        write_reg(REG_MODE, 16'(MODE_GAP));
        write_reg(REG_WINDOW, 16'd0);
        write_reg(REG_MIN_IMPR, 16'd0);
        write_reg(REG_GAP_LIM, 16'hFFFF);
        write_reg(REG_MIN_ITER, 16'd0);
        queue_sample(beat_of(1'b0, 32'd5, 32'd0, 1'b1));
        queue_sample(beat_of(1'b0, 32'd5, 32'd5, 1'b1));
        queue_sample(beat_of(1'b0, 32'd3, 32'd5, 1'b1));
        queue_sample(beat_of(1'b0, 32'd2, 32'd1, 1'b1));
        queue_sample(beat_of(1'b0, 32'd3, 32'd2, 1'b1));
        queue_sample(beat_of(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1));
        queue_sample(beat_of(1'b0, 32'hFFFF_FFFF, 32'd1, 1'b1));
        drain();

        // zero previous sum and zero threshold; wide register values masked
        write_reg(REG_MODE, 16'hFFFE);
        write_reg(REG_WINDOW, 16'hFF41);
        write_reg(REG_UNUSED, 16'hFFFF);
        queue_sample(beat_of(1'b1, 32'd0, 32'd0, 1'b1));
        queue_sample(beat_of(1'b0, 32'd0, 32'd0, 1'b1));
        queue_sample(beat_of(1'b0, 32'd0, 32'd0, 1'b1));
        queue_sample(beat_of(1'b0, 32'd10, 32'd0, 1'b1));
        queue_sample(beat_of(1'b0, 32'd5, 32'd0, 1'b1));
        queue_sample(beat_of(1'b0, 32'd5, 32'd0, 1'b1));
        queue_sample(beat_of(1'b0, 32'd6, 32'd0, 1'b1));
        drain();

        while (random_items < RANDOM_ITEMS)
            random_phase();

        // widest window with ring wraparound and extreme threshold, no idling
        quiet = 1'b1;
        write_reg(REG_MODE, 16'(MODE_STALL));
        write_reg(REG_WINDOW, 16'd63);
        write_reg(REG_MIN_IMPR, 16'hFFFF);
        write_reg(REG_GAP_LIM, 16'($urandom));
        write_reg(REG_MIN_ITER, 16'd0);
        repeat (WIDE_ITEMS)
            queue_sample(beat_of(1'b0, $urandom, $urandom, $urandom_range(1)));
        drain();
        quiet = 1'b0;

        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
src/wcd_pkg.sv
src/wcd_ring.sv
src/windowed_convergence_detector.sv
src/wcd_checker.sv
verif/testbench.sv
